@@ hw/rtl/centered_moving_average_dc_removal_defines.svh @@
// Assertion macros used by the checker of the DC blocker.
// No dependencies; included by the checker file.
`ifndef CENTERED_MOVING_AVERAGE_DC_REMOVAL_DEFINES_SVH
`define CENTERED_MOVING_AVERAGE_DC_REMOVAL_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CMADC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define CMADC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/cmadc_pkg.sv @@
// Shared constants and types for the centered moving-average DC blocker.
// No dependencies.
package cmadc_pkg;

  localparam int DATA_W         = 16;
  localparam int WINDOW_DEFAULT = 64;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_FLUSH  = 1'b1
  } op_t;

endpackage

@@ hw/rtl/cmadc_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cmadc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/cmadc_div.sv @@
// Window average: signed sum divided by WINDOW, truncated toward zero.
// Four-stage reciprocal multiply with one correction step; uses cmadc_pkg.
module cmadc_div #(
  parameter int WINDOW = cmadc_pkg::WINDOW_DEFAULT,
  localparam int SUM_W = cmadc_pkg::DATA_W + 1 + $clog2(WINDOW)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [SUM_W-1:0]           sum,
  output logic                              done,
  output logic signed [cmadc_pkg::DATA_W-1:0] avg
);
  import cmadc_pkg::*;

  localparam int MAG_W = SUM_W - 1;
  localparam int Q_W   = DATA_W + 1;
  // floor(2^MAG_W / WINDOW): quotient estimate is exact or one low
  localparam logic [MAG_W-1:0] RECIP = MAG_W'((64'd1 << MAG_W) / WINDOW);
  localparam logic [MAG_W-1:0] WIN   = MAG_W'(WINDOW);

  logic [3:0] vld;

  logic signed [SUM_W-1:0]  sum_neg;
  logic [MAG_W-1:0]         mag1, mag2, mag3;
  logic                     neg1, neg2, neg3;
  logic [2*MAG_W-1:0]       prod2;
  logic [Q_W-1:0]           q0, q3;
  logic [Q_W+MAG_W-1:0]     qw;
  logic [MAG_W-1:0]         qw3;
  logic [MAG_W-1:0]         rem;
  logic [Q_W-1:0]           q_fix, q_sgn;

  assign sum_neg = -sum;
  assign q0      = prod2[MAG_W +: Q_W];
  assign qw      = q0 * WIN;
  assign rem     = mag3 - qw3;
  assign q_fix   = (rem >= WIN) ? q3 + 1'b1 : q3;
  assign q_sgn   = neg3 ? -q_fix : q_fix;
  assign done    = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      avg <= '0;
    end else begin
      vld <= {vld[2:0], start};
      if (vld[2]) begin
        avg <= q_sgn[DATA_W-1:0];
      end
    end
    // payload stages
    neg1  <= sum[SUM_W-1];
    mag1  <= sum[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum[MAG_W-1:0];
    neg2  <= neg1;
    mag2  <= mag1;
    prod2 <= mag1 * RECIP;
    neg3  <= neg2;
    mag3  <= mag2;
    q3    <= q0;
    qw3   <= qw[MAG_W-1:0];
  end

endmodule

@@ hw/rtl/centered_moving_average_dc_removal.sv @@
// Top level of the centered moving-average DC blocker.
// Uses cmadc_pkg, cmadc_ram (sample ring) and cmadc_div (window average).
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------
//   input   | in_valid / in_stall  | op (1), sample (s16)
//   output  | out_valid / out_stall| value (s16), last (1)
//
// Each sample is written to the ring; once the ring is full it also takes
// two reads through the single read port (centre, then oldest); each ends with
// the four-stage average unit refreshing the mean after the running sum changes.
// A flush passes each result beat through S_FRD, S_FDAT and S_EMIT, then returns to empty.
// Reset is synchronous; the ring needs no clearing. in_stall is high while
// an item is in work; a stalled output beat holds until it is taken.
module centered_moving_average_dc_removal #(
  parameter int WINDOW = cmadc_pkg::WINDOW_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                op,
  input  logic signed [cmadc_pkg::DATA_W-1:0] sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cmadc_pkg::DATA_W-1:0] value,
  output logic                                last
);
  import cmadc_pkg::*;

  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = DATA_W + 1 + $clog2(WINDOW);
  localparam logic [POS_W-1:0]  HALF_POS  = POS_W'(WINDOW / 2);
  localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(WINDOW - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);
  localparam logic [FILL_W-1:0] FILL_HALF = FILL_W'(WINDOW / 2);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_CTR, S_OLD, S_EMIT, S_DIV, S_FRD, S_FDAT, S_CLR
  } state_t;

  function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
    return (p == LAST_POS) ? '0 : p + 1'b1;
  endfunction

  state_t                    state, ret_state;
  op_t                       op_q;
  logic signed [DATA_W-1:0]  smp_q;
  logic signed [SUM_W-1:0]   sum;
  logic [FILL_W-1:0]         fill;
  logic [POS_W-1:0]          wp, rp, fp;
  logic signed [DATA_W-1:0]  pend_value;
  logic                      pend_last;
  logic                      div_start;

  logic                      div_done;
  logic signed [DATA_W-1:0]  avg;
  logic                      ram_we;
  logic [POS_W-1:0]          ram_raddr;
  logic [DATA_W-1:0]         ram_rdata;
  logic signed [DATA_W-1:0]  rdata;
  logic signed [DATA_W-1:0]  ctr_diff;
  logic signed [SUM_W-1:0]   smp_ext, old_ext;
  logic                      full, out_free, flush_last;

  assign in_stall   = rst || (state != S_IDLE);
  assign full       = (fill == FILL_FULL);
  assign out_free   = !out_valid || !out_stall;
  assign rdata      = signed'(ram_rdata);
  assign ctr_diff   = rdata - avg;
  assign smp_ext    = SUM_W'(smp_q);
  assign old_ext    = SUM_W'(rdata);
  // before fill, fill stays below WINDOW and fits a position
  assign flush_last = full ? (pos_inc(fp) == wp) : (pos_inc(fp) == fill[POS_W-1:0]);
  assign ram_we     = ((state == S_DISP) && (op_q == OP_SAMPLE) && !full) ||
                      (state == S_OLD);

  always_comb begin
    unique case (state)
      S_DISP:  ram_raddr = rp;
      S_CTR:   ram_raddr = wp;
      default: ram_raddr = fp;
    endcase
  end

  cmadc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (smp_q),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cmadc_div #(
    .WINDOW (WINDOW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sum   (sum),
    .done  (div_done),
    .avg   (avg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sum       <= '0;
      fill      <= '0;
      wp        <= '0;
      rp        <= HALF_POS;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      // a beat is raised in S_EMIT and held while stalled
      out_valid <= (state == S_EMIT) || (out_valid && out_stall);
      div_start <= ((state == S_DISP) && (op_q == OP_SAMPLE) && !full &&
                    (fill >= FILL_HALF)) ||
                   ((state == S_EMIT) && out_free && (ret_state == S_DIV));
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q  <= op_t'(op);
            smp_q <= sample;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          if (op_q == OP_SAMPLE) begin
            if (!full) begin
              sum  <= sum + smp_ext;
              wp   <= pos_inc(wp);
              fill <= fill + 1'b1;
              if (fill < FILL_HALF) begin
                pend_value <= smp_q;
                pend_last  <= 1'b1;
                ret_state  <= S_DIV;
                state      <= S_EMIT;
              end else begin
                state <= S_DIV;
              end
            end else begin
              state <= S_CTR;
            end
          end else begin
            if (full) begin
              fp    <= rp;
              state <= S_FRD;
            end else if (fill > FILL_HALF) begin
              fp    <= HALF_POS;
              state <= S_FRD;
            end else begin
              state <= S_CLR;
            end
          end
        end
        S_CTR: begin
          // centre entry is on the read port now; oldest is fetched next
          pend_value <= ctr_diff;
          pend_last  <= 1'b1;
          state      <= S_OLD;
        end
        S_OLD: begin
          sum       <= sum - old_ext + smp_ext;
          wp        <= pos_inc(wp);
          rp        <= pos_inc(rp);
          ret_state <= S_DIV;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            value <= pend_value;
            last  <= pend_last;
            state <= ret_state;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_IDLE;
          end
        end
        S_FRD: begin
          state <= S_FDAT;
        end
        S_FDAT: begin
          pend_value <= full ? ctr_diff : rdata;
          pend_last  <= flush_last;
          ret_state  <= flush_last ? S_CLR : S_FRD;
          fp         <= pos_inc(fp);
          state      <= S_EMIT;
        end
        S_CLR: begin
          sum   <= '0;
          fill  <= '0;
          wp    <= '0;
          rp    <= HALF_POS;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/cmadc_checker.sv @@
// Port-level checker for the DC blocker, bound to the top level.
// Uses the assertion macros header and cmadc_pkg widths.
`include "centered_moving_average_dc_removal_defines.svh"

module cmadc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                op,
  input logic signed [cmadc_pkg::DATA_W-1:0] sample,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [cmadc_pkg::DATA_W-1:0] value,
  input logic                                last
);

  logic in_beat;
  logic in_flush;

  assign in_beat  = in_valid && !in_stall;
  assign in_flush = in_beat && op && (sample == sample);

  // one item at a time: the block is busy right after taking a beat
  `CMADC_ASSERT_NEXT(a_busy_after_beat, clk, rst, in_beat, in_stall, "stall low after input beat")

  // results only come from an item in work
  `CMADC_ASSERT_NOW(a_out_while_busy, clk, rst, $rose(out_valid), in_stall, "output beat while idle")

  // no result can be ready the cycle after a beat is taken
  `CMADC_ASSERT_NEXT(a_no_instant_out, clk, rst, in_beat || in_flush, !$rose(out_valid), "output too early")

  // stalled output beat holds
  `CMADC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(value) && $stable(last), "stalled output beat changed")

endmodule

bind centered_moving_average_dc_removal cmadc_checker u_cmadc_checker (.*);

@@ test/centered_moving_average_dc_removal_test.sv @@
// Self-checking testbench for centered_moving_average_dc_removal.
// Uses cmadc_pkg; drives sample streams and flushes, predicts every output beat.
// Directed table first, then random streams under several idle/stall phases.
module centered_moving_average_dc_removal_test;
  import cmadc_pkg::*;

  localparam int WIN       = WINDOW_DEFAULT;
  localparam int HALF      = WIN / 2;
  localparam int RND_ITEMS = 290;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } beat_t;

  // typed = 1: expected beats come from the row itself (n_exp beats of exp_val)
  typedef struct {
    op_t                      op;
    logic signed [DATA_W-1:0] smp;
    bit                       typed;
    int                       n_exp;
    logic signed [DATA_W-1:0] exp_val;
  } stim_row_t;

  localparam int N_ROWS = 19;
  stim_row_t directed_rows [N_ROWS] = '{
    '{OP_FLUSH,  16'sd0,      1'b1, 0, 16'sd0},      // flush on empty ring
    '{OP_SAMPLE, 16'sh7FFF,   1'b1, 1, 16'sh7FFF},
    '{OP_SAMPLE, -16'sh8000,  1'b1, 1, -16'sh8000},
    '{OP_SAMPLE, 16'sd0,      1'b1, 1, 16'sd0},
    '{OP_SAMPLE, 16'sd1,      1'b1, 1, 16'sd1},
    '{OP_SAMPLE, -16'sd1,     1'b1, 1, -16'sd1},
    '{OP_SAMPLE, 16'sh5555,   1'b1, 1, 16'sh5555},
    '{OP_SAMPLE, -16'sh5556,  1'b1, 1, -16'sh5556},
    '{OP_FLUSH,  16'sh7FFF,   1'b1, 0, 16'sd0},      // nothing pending yet
    '{OP_SAMPLE, -16'sh8000,  1'b1, 1, -16'sh8000},  // back to empty: raw again
    '{OP_SAMPLE, 16'sh7FFF,   1'b1, 1, 16'sh7FFF},
    '{OP_FLUSH,  -16'sd1,     1'b1, 0, 16'sd0},
    '{OP_SAMPLE, 16'sh7FFF,   1'b0, 0, 16'sd0},
    '{OP_SAMPLE, -16'sh8000,  1'b0, 0, 16'sd0},
    '{OP_SAMPLE, 16'sd12345,  1'b0, 0, 16'sd0},
    '{OP_SAMPLE, -16'sd12345, 1'b0, 0, 16'sd0},
    '{OP_SAMPLE, 16'sd255,    1'b0, 0, 16'sd0},
    '{OP_SAMPLE, -16'sd256,   1'b0, 0, 16'sd0},
    '{OP_FLUSH,  16'sd0,      1'b0, 0, 16'sd0}
  };

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     op = OP_SAMPLE;
  logic signed [DATA_W-1:0] sample = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  centered_moving_average_dc_removal #(.WINDOW(WIN)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .last      (last)
  );

  always #5 clk = ~clk;

  // shadow state of the DC blocker
  logic signed [DATA_W-1:0] ring_mem [WIN];
  longint                   ring_sum;
  int                       fill_cnt;
  int                       wr_idx;
  int                       ctr_idx;

  beat_t step_beats[$];
  beat_t expected_beats[$];

  int phase = 0;
  int rnd_sent = 0;
  int items_in = 0;
  int flushes = 0;
  int full_samples = 0;
  int beats_checked = 0;
  int mismatches = 0;
  int strays = 0;

  function automatic void clear_blocker();
    for (int i = 0; i < WIN; i++) ring_mem[i] = '0;
    ring_sum = 0;
    fill_cnt = 0;
    wr_idx   = 0;
    ctr_idx  = HALF;
  endfunction

  // Advance the shadow state by one input beat; resulting beats land in step_beats.
  function automatic void blocker_step(op_t o, logic signed [DATA_W-1:0] s);
    longint mean;
    int     rp;
    beat_t  b;
    step_beats.delete();
    if (o == OP_SAMPLE) begin
      if (fill_cnt < WIN) begin
        ring_mem[wr_idx] = s;
        ring_sum += s;
        wr_idx = (wr_idx + 1) % WIN;
        if (fill_cnt < HALF) begin
          b.value = s;
          b.last  = 1'b1;
          step_beats = {step_beats, b};
        end
        fill_cnt++;
      end else begin
        mean = ring_sum / WIN;  // truncates toward zero
        b.value = DATA_W'(longint'(ring_mem[ctr_idx]) - mean);
        b.last  = 1'b1;
        step_beats = {step_beats, b};
        ring_sum -= ring_mem[wr_idx];
        ring_mem[wr_idx] = s;
        ring_sum += s;
        wr_idx  = (wr_idx + 1) % WIN;
        ctr_idx = (ctr_idx + 1) % WIN;
        full_samples++;
      end
    end else begin
      if (fill_cnt >= WIN) begin
        // drain the centre entries not yet emitted, all against one mean
        mean = ring_sum / WIN;
        rp = ctr_idx;
        while (rp != wr_idx) begin
          b.value = DATA_W'(longint'(ring_mem[rp]) - mean);
          b.last  = 1'b0;
          step_beats = {step_beats, b};
          rp = (rp + 1) % WIN;
        end
      end else begin
        for (int i = HALF; i < fill_cnt; i++) begin
          b.value = ring_mem[i];
          b.last  = 1'b0;
          step_beats = {step_beats, b};
        end
      end
      if (step_beats.size() > 0) step_beats[step_beats.size()-1].last = 1'b1;
      clear_blocker();
      flushes++;
    end
  endfunction

  function automatic int send_idle_pct();
    case (phase)
      1:       return 84;
      3:       return 35;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (phase)
      2:       return 84;
      3:       return 35;
      default: return 0;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_sample(int kind, int dc);
    case (kind)
      0: return DATA_W'($urandom);
      1: return DATA_W'(dc + int'($urandom_range(0, 128)) - 64);
      default: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh7FFF;
          1:       return -16'sh8000;
          2:       return -16'sd1;
          3:       return 16'sd1;
          default: return 16'sd0;
        endcase
      end
    endcase
  endfunction

  task automatic put_item(op_t o, logic signed [DATA_W-1:0] s, bit typed, int n_exp,
                          logic signed [DATA_W-1:0] exp_val);
    beat_t b;
    phase = (rnd_sent * 4) / RND_ITEMS;
    if (phase > 3) phase = 3;
    while ($urandom_range(0, 99) < send_idle_pct()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    sample   <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    blocker_step(o, s);
    if (typed) begin
      for (int i = 0; i < n_exp; i++) begin
        b.value = exp_val;
        b.last  = (i == n_exp - 1);
        expected_beats = {expected_beats, b};
      end
    end else begin
      foreach (step_beats[i]) expected_beats = {expected_beats, step_beats[i]};
    end
    items_in++;
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct());
  end

  // output checker
  always @(posedge clk) begin
    beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        strays++;
        if (mismatches + strays <= 10)
          $display("unexpected output beat: value=%0d last=%0b", value, last);
      end else begin
        want = expected_beats.pop_front();
        beats_checked++;
        if (value !== want.value || last !== want.last) begin
          mismatches++;
          if (mismatches + strays <= 10)
            $display("beat %0d mismatch: value exp %0d got %0d, last exp %0b got %0b",
                     beats_checked, want.value, value, want.last, last);
        end
      end
    end
  end

  initial begin
    int len;
    int kind;
    int dc;
    clear_blocker();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < N_ROWS; r++)
      put_item(directed_rows[r].op, directed_rows[r].smp, directed_rows[r].typed,
               directed_rows[r].n_exp, directed_rows[r].exp_val);

    // random streams: mostly sample runs closed by a flush, some short or half-filled
    while (rnd_sent < RND_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1:    len = $urandom_range(0, HALF);
        2, 3:    len = $urandom_range(HALF + 1, WIN - 1);
        default: len = $urandom_range(WIN, WIN + 60);
      endcase
      kind = $urandom_range(0, 2);
      dc   = int'($urandom_range(0, 65535)) - 32768;
      for (int k = 0; k < len && rnd_sent < RND_ITEMS - 1; k++) begin
        put_item(OP_SAMPLE, pick_sample(kind, dc), 1'b0, 0, '0);
        rnd_sent++;
      end
      put_item(OP_FLUSH, DATA_W'($urandom), 1'b0, 0, '0);
      rnd_sent++;
      if ($urandom_range(0, 7) == 0) begin
        // back-to-back flush: must give nothing
        put_item(OP_FLUSH, DATA_W'($urandom), 1'b0, 0, '0);
        rnd_sent++;
      end
    end
    in_valid <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d input beats: %0d flushes, %0d samples on a full window",
             items_in, flushes, full_samples);
    $display("%0d output beats checked, %0d mismatches, %0d unexpected, %0d missing",
             beats_checked, mismatches, strays, expected_beats.size());
    if (mismatches == 0 && strays == 0 && expected_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("FAIL");
    $finish;
  end

endmodule
